/* rtl/bpsa_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bpsa_pkg
// Shared sizes, codes and helpers of the pool segment allocator.
// ----------------------------------------------------------------------------
package bpsa_pkg;

   localparam int MAX_SEGMENTS = 64;
   localparam int IDX_W        = (MAX_SEGMENTS > 2) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int CNT_W        = IDX_W + 1;
   localparam int SEG_ID_W     = 6;
   localparam int BYTE_W       = 32;
   localparam int CMP_W        = CNT_W + SEG_ID_W;

   localparam logic [BYTE_W-1:0] CAPACITY_RESET = 32'd268435456;

   typedef enum logic {
      CMD_ALLOC   = 1'b0,
      CMD_RELEASE = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      ST_NEW        = 3'd0,
      ST_REUSED     = 3'd1,
      ST_NOT_POOLED = 3'd2,
      ST_RELEASED   = 3'd3,
      ST_BAD_ID     = 3'd4
   } status_type;

   // entry write of start and length
   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  addr;
      logic [BYTE_W-1:0] start;
      logic [BYTE_W-1:0] length;
   } seg_wr_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic             busy;
   } busy_wr_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
   } seg_rd_type;

   typedef struct packed {
      logic [BYTE_W-1:0] start;
      logic [BYTE_W-1:0] length;
      logic              busy;
   } seg_data_type;

   typedef struct packed {
      logic                valid;
      status_type          status;
      logic [SEG_ID_W-1:0] index;
      logic [BYTE_W-1:0]   offset;
   } result_type;

   // low bits of a table id as the reported segment id
   function automatic logic [SEG_ID_W-1:0] to_seg_id(input logic [IDX_W-1:0] id);
      logic [IDX_W+SEG_ID_W-1:0] wide;
      wide = {{SEG_ID_W{1'b0}}, id};
      return wide[SEG_ID_W-1:0];
   endfunction

endpackage
`default_nettype wire

/* rtl/bpsa_seg_table.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bpsa_seg_table
// Segment table: start/length memory and busy-flag memory, one write port
// each, a shared read address and a registered read.
// ----------------------------------------------------------------------------
module bpsa_seg_table
   import bpsa_pkg::*;
(
   input  wire logic         clock,
   input  wire seg_wr_type   seg_wr,
   input  wire busy_wr_type  busy_wr,
   input  wire seg_rd_type   seg_rd,
   output seg_data_type      seg_data
);

   logic [BYTE_W-1:0] start_mem  [MAX_SEGMENTS];
   logic [BYTE_W-1:0] length_mem [MAX_SEGMENTS];
   logic              busy_mem   [MAX_SEGMENTS];

   logic [BYTE_W-1:0] rd_start_ff;
   logic [BYTE_W-1:0] rd_length_ff;
   logic              rd_busy_ff;

   always_ff @(posedge clock) begin
      if (seg_wr.en) begin
         start_mem[seg_wr.addr]  <= seg_wr.start;
         length_mem[seg_wr.addr] <= seg_wr.length;
      end
      if (seg_rd.en) begin
         rd_start_ff  <= start_mem[seg_rd.addr];
         rd_length_ff <= length_mem[seg_rd.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (busy_wr.en) begin
         busy_mem[busy_wr.addr] <= busy_wr.busy;
      end
      if (seg_rd.en) begin
         rd_busy_ff <= busy_mem[seg_rd.addr];
      end
   end

   assign seg_data = '{start: rd_start_ff, length: rd_length_ff, busy: rd_busy_ff};

endmodule
`default_nettype wire

/* rtl/bpsa_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bpsa_ctrl
// Command sequencer: release, bump allocation and first-fit search over the
// segment table, one entry read per cycle.
// ----------------------------------------------------------------------------
module bpsa_ctrl
   import bpsa_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_cmd,
   input  wire logic [BYTE_W-1:0]   req_bytes,
   input  wire logic [SEG_ID_W-1:0] req_rel,
   input  wire logic [BYTE_W-1:0]   capacity,
   output seg_wr_type               seg_wr,
   output busy_wr_type              busy_wr,
   output seg_rd_type               seg_rd,
   input  wire seg_data_type        seg_data,
   output result_type               res,
   input  wire logic                res_ready
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_RESP
   } state_type;

   state_type           state_ff, state_in;
   logic                cmd_ff, cmd_in;
   logic [BYTE_W-1:0]   bytes_ff, bytes_in;
   logic [SEG_ID_W-1:0] rel_ff, rel_in;
   logic [BYTE_W:0]     bump_ff, bump_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    chk_ff, chk_in;
   status_type          status_ff, status_in;
   logic [SEG_ID_W-1:0] index_ff, index_in;
   logic [BYTE_W-1:0]   offset_ff, offset_in;

   logic [CMP_W-1:0]    rel_ext;
   logic [CMP_W-1:0]    cnt_ext;
   logic [BYTE_W:0]     cap_ext;
   logic [BYTE_W:0]     bump_sum;
   logic                bump_open;
   logic                bump_fits;
   logic                hit;
   logic [CNT_W-1:0]    chk_next;

   assign rel_ext   = {{CNT_W{1'b0}}, rel_ff};
   assign cnt_ext   = {{SEG_ID_W{1'b0}}, count_ff};
   assign cap_ext   = {1'b0, capacity};
   assign bump_sum  = bump_ff + {1'b0, bytes_ff};
   assign bump_open = (count_ff < CNT_W'(MAX_SEGMENTS)) && (bump_ff < cap_ext);
   assign bump_fits = bump_sum <= cap_ext;
   assign hit       = (seg_data.length >= bytes_ff) && !seg_data.busy;
   assign chk_next  = {1'b0, chk_ff} + CNT_W'(1);

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      bytes_in  = bytes_ff;
      rel_in    = rel_ff;
      bump_in   = bump_ff;
      count_in  = count_ff;
      chk_in    = chk_ff;
      status_in = status_ff;
      index_in  = index_ff;
      offset_in = offset_ff;
      seg_wr    = '0;
      busy_wr   = '0;
      seg_rd    = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_cmd;
               bytes_in = req_bytes;
               rel_in   = req_rel;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (cmd_ff == CMD_RELEASE) begin
               if (rel_ext < cnt_ext) begin
                  busy_wr   = '{en: 1'b1, addr: rel_ext[IDX_W-1:0], busy: 1'b0};
                  status_in = ST_RELEASED;
                  index_in  = rel_ff;
               end else begin
                  status_in = ST_BAD_ID;
                  index_in  = '0;
               end
               offset_in = '0;
               state_in  = S_RESP;
            end else if (bump_open && bump_fits) begin
               bump_in   = bump_sum;
               seg_wr    = '{en: 1'b1, addr: count_ff[IDX_W-1:0],
                             start: bump_ff[BYTE_W-1:0], length: bytes_ff};
               busy_wr   = '{en: 1'b1, addr: count_ff[IDX_W-1:0], busy: 1'b1};
               count_in  = count_ff + CNT_W'(1);
               status_in = ST_NEW;
               index_in  = to_seg_id(count_ff[IDX_W-1:0]);
               offset_in = bump_ff[BYTE_W-1:0];
               state_in  = S_RESP;
            end else begin
               // overflow still advances the offset, closing the bump region
               if (bump_open) begin
                  bump_in = bump_sum;
               end
               if (count_ff == '0) begin
                  status_in = ST_NOT_POOLED;
                  index_in  = '0;
                  offset_in = '0;
                  state_in  = S_RESP;
               end else begin
                  seg_rd   = '{en: 1'b1, addr: '0};
                  chk_in   = '0;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (hit) begin
               busy_wr   = '{en: 1'b1, addr: chk_ff, busy: 1'b1};
               status_in = ST_REUSED;
               index_in  = to_seg_id(chk_ff);
               offset_in = seg_data.start;
               state_in  = S_RESP;
            end else if (chk_next == count_ff) begin
               status_in = ST_NOT_POOLED;
               index_in  = '0;
               offset_in = '0;
               state_in  = S_RESP;
            end else begin
               // prefetch the next entry while this one is checked
               seg_rd   = '{en: 1'b1, addr: chk_next[IDX_W-1:0]};
               chk_in   = chk_next[IDX_W-1:0];
            end
         end
         S_RESP: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         bump_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         bump_ff  <= bump_in;
         count_ff <= count_in;
      end
      cmd_ff    <= cmd_in;
      bytes_ff  <= bytes_in;
      rel_ff    <= rel_in;
      chk_ff    <= chk_in;
      status_ff <= status_in;
      index_ff  <= index_in;
      offset_ff <= offset_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign res = '{valid: (state_ff == S_RESP), status: status_ff,
                  index: index_ff, offset: offset_ff};

   a_new_has_room: assert property (@(posedge clock) disable iff (reset)
      seg_wr.en |-> (count_ff < CNT_W'(MAX_SEGMENTS)))
      else $error("segment recorded with a full table");

   a_new_bumps_count: assert property (@(posedge clock) disable iff (reset)
      seg_wr.en |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("segment count did not advance after a new segment");

   a_read_below_count: assert property (@(posedge clock) disable iff (reset)
      seg_rd.en |-> ({1'b0, seg_rd.addr} < count_ff))
      else $error("table read beyond recorded segments");

   a_reuse_marks_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && status_in == ST_REUSED && state_in == S_RESP)
         |-> (busy_wr.en && busy_wr.busy && busy_wr.addr == chk_ff))
      else $error("reused segment not marked busy");

endmodule
`default_nettype wire

/* rtl/bump_pool_segment_allocator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bump_pool_segment_allocator
// Pool allocator: bump region first, then first-fit reuse of freed segments.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req      in         req_tvalid/tready    tuser cmd, tdata bytes/segment id
//  rsp      out        rsp_tvalid/tready    tuser status, tdata id/offset
//  csr      in         csr_valid/ready      pool capacity, always ready
//
//  A release or a new bump segment passes the execute and response states into
//  the output register; a reuse search scans the table read port, one entry per
//  cycle, until a free segment that fits is found or the recorded ones run out.
//  Reset clears the offset, the segment count and sets capacity to 256 MiB;
//  the table memories need no clearing pass.
//  A new transaction is accepted while a result waits in the output register.
// ----------------------------------------------------------------------------
module bump_pool_segment_allocator
   import bpsa_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [0:0]  req_tuser,   // [0] cmd
   input  wire logic [39:0] req_tdata,   // [31:0] request_bytes, [37:32] release_segment
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [2:0]       rsp_tuser,   // [2:0] status
   output logic [39:0]      rsp_tdata,   // [5:0] segment_index, [37:6] byte_offset
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_wdata
);

   logic [BYTE_W-1:0]   capacity_ff;
   logic                rsp_valid_ff;
   status_type          rsp_status_ff;
   logic [SEG_ID_W-1:0] rsp_index_ff;
   logic [BYTE_W-1:0]   rsp_offset_ff;

   seg_wr_type   seg_wr;
   busy_wr_type  busy_wr;
   seg_rd_type   seg_rd;
   seg_data_type seg_data;
   result_type   res;
   logic         out_free;

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (csr_valid) begin
         capacity_ff <= csr_wdata;
      end
   end

   // hold the result until the downstream side takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= res.valid;
      end
      if (out_free && res.valid) begin
         rsp_status_ff <= res.status;
         rsp_index_ff  <= res.index;
         rsp_offset_ff <= res.offset;
      end
   end

   bpsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_cmd   (req_tuser[0]),
      .req_bytes (req_tdata[31:0]),
      .req_rel   (req_tdata[37:32]),
      .capacity  (capacity_ff),
      .seg_wr    (seg_wr),
      .busy_wr   (busy_wr),
      .seg_rd    (seg_rd),
      .seg_data  (seg_data),
      .res       (res),
      .res_ready (out_free)
   );

   bpsa_seg_table u_table (
      .clock    (clock),
      .seg_wr   (seg_wr),
      .busy_wr  (busy_wr),
      .seg_rd   (seg_rd),
      .seg_data (seg_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {2'b00, rsp_offset_ff, rsp_index_ff};

endmodule
`default_nettype wire

/* test/bpsa_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bpsa_checker
// Watches the request, result and capacity channels of the pool segment
// allocator, predicts every grant or release answer from a private copy of
// the pool state, and compares each accepted result against the oldest one due.
// ----------------------------------------------------------------------------
module bpsa_checker
   import bpsa_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [0:0]  req_tuser,   // [0] cmd
   input  wire logic [39:0] req_tdata,   // [31:0] request_bytes, [37:32] release_segment
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [2:0]  rsp_tuser,   // [2:0] status
   input  wire logic [39:0] rsp_tdata,   // [5:0] segment_index, [37:6] byte_offset
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [31:0] csr_wdata,
   output int               mismatches,
   output int               outstanding
);

   typedef struct packed {
      status_type          status;
      logic [SEG_ID_W-1:0] seg;
      logic [BYTE_W-1:0]   offset;
   } grant_type;

   logic [BYTE_W-1:0] pool_cap;
   logic [BYTE_W:0]   bump_pos;
   logic [CNT_W-1:0]  seg_count;
   logic [BYTE_W-1:0] seg_start [MAX_SEGMENTS];
   logic [BYTE_W-1:0] seg_len   [MAX_SEGMENTS];
   logic              seg_busy  [MAX_SEGMENTS];

   grant_type grants_due [$];
   int        fail_count;

   // answer to one command; updates the private pool state
   function automatic grant_type grant_for(input cmd_type c, input logic [BYTE_W-1:0] nbytes,
                                           input logic [SEG_ID_W-1:0] rel);
      grant_type       g;
      logic [BYTE_W:0] end_pos;
      int              i;
      g.status = ST_NOT_POOLED;
      g.seg    = '0;
      g.offset = '0;
      if (c == CMD_RELEASE) begin
         if (rel < seg_count) begin
            seg_busy[rel] = 1'b0;
            g.status      = ST_RELEASED;
            g.seg         = rel;
         end else begin
            g.status = ST_BAD_ID;
         end
         return g;
      end
      if (seg_count < MAX_SEGMENTS && bump_pos < {1'b0, pool_cap}) begin
         end_pos = bump_pos + {1'b0, nbytes};
         if (end_pos <= {1'b0, pool_cap}) begin
            seg_start[seg_count] = bump_pos[BYTE_W-1:0];
            seg_len[seg_count]   = nbytes;
            seg_busy[seg_count]  = 1'b1;
            g.status  = ST_NEW;
            g.seg     = seg_count[SEG_ID_W-1:0];
            g.offset  = bump_pos[BYTE_W-1:0];
            seg_count = seg_count + 1'b1;
            bump_pos  = end_pos;
            return g;
         end
         // overflow still moves the offset, closing the bump region
         bump_pos = end_pos;
      end
      for (i = 0; i < seg_count; i++) begin
         if (!seg_busy[i] && seg_len[i] >= nbytes) begin
            seg_busy[i] = 1'b1;
            g.status    = ST_REUSED;
            g.seg       = SEG_ID_W'(i);
            g.offset    = seg_start[i];
            return g;
         end
      end
      return g;
   endfunction

   always @(posedge clock) begin
      grant_type due;
      grant_type fresh;
      if (reset) begin
         pool_cap   = CAPACITY_RESET;
         bump_pos   = '0;
         seg_count  = '0;
         fail_count = 0;
         grants_due.delete();
      end else begin
         if (csr_valid && csr_ready)
            pool_cap = csr_wdata;
         // compare first: a result never belongs to a transaction of this edge
         if (rsp_tvalid && rsp_tready) begin
            if (grants_due.size() == 0) begin
               $display("%0t: result with nothing due, got status %0d index %0d offset 0x%08h",
                        $time, rsp_tuser, rsp_tdata[5:0], rsp_tdata[37:6]);
               fail_count++;
            end else begin
               due = grants_due.pop_front();
               if (rsp_tuser !== due.status) begin
                  $display("%0t: status expected %0d, got %0d", $time, due.status, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tdata[5:0] !== due.seg) begin
                  $display("%0t: segment_index expected %0d, got %0d",
                           $time, due.seg, rsp_tdata[5:0]);
                  fail_count++;
               end
               if (rsp_tdata[37:6] !== due.offset) begin
                  $display("%0t: byte_offset expected 0x%08h, got 0x%08h",
                           $time, due.offset, rsp_tdata[37:6]);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            fresh = grant_for(cmd_type'(req_tuser[0]), req_tdata[31:0], req_tdata[37:32]);
            grants_due.insert(grants_due.size(), fresh);
         end
      end
      mismatches  <= fail_count;
      outstanding <= grants_due.size();
   end

endmodule

/* test/tb_bump_pool_segment_allocator.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bump_pool_segment_allocator
// Drives allocate and release commands into the pool allocator under random
// back-pressure, moves the pool capacity between phases, and reports the
// verdict of the checker that runs beside the block.
// ----------------------------------------------------------------------------
module tb_bump_pool_segment_allocator;
   import bpsa_pkg::*;

   localparam int HOLD_CYCLES = 400;
   localparam int HOLD_AT     = 300;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [0:0]  req_tuser  = '0;
   logic [39:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [2:0]  rsp_tuser;
   logic [39:0] rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_wdata  = '0;

   int mismatches;
   int outstanding;
   int n_alloc   = 0;
   int n_release = 0;
   int n_cfg     = 0;
   bit sender_calm = 1'b0;

   bump_pool_segment_allocator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   bpsa_checker grant_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb_bump_pool_segment_allocator: done, errors");
      $finish;
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap(input bit calm);
      int roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 55)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_item(input cmd_type c, input logic [31:0] nbytes,
                            input logic [5:0] seg_id);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= c;
      req_tdata  <= {2'b00, seg_id, nbytes};
      do @(posedge clock); while (!req_tready);
      if (c == CMD_ALLOC)
         n_alloc++;
      else
         n_release++;
      gap = pick_gap(sender_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic alloc(input logic [31:0] nbytes);
      send_item(CMD_ALLOC, nbytes, 6'($urandom_range(0, 63)));
   endtask

   task automatic release_seg(input logic [5:0] seg_id);
      send_item(CMD_RELEASE, $urandom(), seg_id);
   endtask

   // drain, then write the capacity while the block is idle
   task automatic set_capacity(input logic [31:0] value);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (8) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      n_cfg++;
   endtask

   task automatic run_phase(input int count, input logic [31:0] cap, input bit wide);
      int          roll;
      logic [31:0] nbytes;
      set_capacity(cap);
      sender_calm = ($urandom_range(0, 2) == 0);
      repeat (count) begin
         roll = $urandom_range(0, 99);
         if (roll < (wide ? 45 : 30)) begin
            release_seg(6'($urandom_range(0, 63)));
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 60)
               nbytes = $urandom_range(0, 4095);
            else if (roll < 68)
               nbytes = '0;
            else if (roll < 88 || !wide)
               nbytes = $urandom_range(0, 32'h0FFF_FFFF);
            else
               nbytes = $urandom();
            alloc(nbytes);
         end
      end
      sender_calm = 1'b0;
   endtask

   // result side: random stalls, one long hold to back up the request channel
   initial begin
      int taken;
      int gap;
      taken = 0;
      while (reset) @(posedge clock);
      forever begin
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
         if (taken == HOLD_AT) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            gap = pick_gap((taken / 64) % 3 == 0);
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset capacity, empty table, exact fit, reuse, bad ids
      release_seg(6'd0);
      alloc(32'd0);
      alloc(32'd100);
      release_seg(6'd1);
      release_seg(6'd1);
      alloc(32'd50);
      alloc(CAPACITY_RESET - 32'd150);
      alloc(32'd80);
      release_seg(6'd63);
      release_seg(6'd0);
      alloc(32'd0);
      alloc(32'hFFFF_FFFF);

      // reopen the bump region by a hair, then overflow it by one byte
      set_capacity(CAPACITY_RESET + 32'h1000);
      release_seg(6'd3);
      alloc(32'h0000_1001);
      alloc(32'd1);

      set_capacity(32'h0000_0000);
      release_seg(6'd2);
      alloc(32'd50);
      alloc(32'd51);

      set_capacity(32'hFFFF_FFFF);
      alloc(32'h1234_5678);
      release_seg(6'd4);
      alloc(32'd0);

      // bump phases fill the table, then reuse phases churn it
      run_phase(25, 32'h4000_0000, 1'b0);
      run_phase(25, 32'h8000_0000, 1'b0);
      run_phase(25, 32'hC000_0000, 1'b0);
      run_phase(25, 32'hF000_0000, 1'b0);
      run_phase(110, $urandom(), 1'b1);
      run_phase(110, 32'h0000_0000, 1'b1);
      run_phase(110, $urandom(), 1'b1);
      run_phase(110, 32'hFFFF_FFFF, 1'b1);
      run_phase(110, $urandom(), 1'b1);
      run_phase(110, $urandom(), 1'b1);

      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (80) @(posedge clock);

      $display("covered %0d allocations and %0d releases over %0d capacity writes",
               n_alloc, n_release, n_cfg);
      $display("result side held off %0d cycles once with requests still offered",
               HOLD_CYCLES);
      if (mismatches == 0 && outstanding == 0)
         $display("tb_bump_pool_segment_allocator: done, clean");
      else
         $display("tb_bump_pool_segment_allocator: done, errors");
      $finish;
   end

endmodule
